/* rtl/core/clcd_pkg.sv */
// Shared types and constants of the character LCD controller.
package clcd_pkg;

  localparam int unsigned DdramDepth = 128;
  localparam int unsigned CgramDepth = 64;
  localparam int unsigned DdAddrW    = $clog2(DdramDepth);
  localparam int unsigned CgAddrW    = $clog2(CgramDepth);
  localparam int unsigned CfgDataW   = 24;
  localparam int unsigned CfgIndexW  = 1;

  localparam logic [15:0] ShortBusyReset = 16'd37;
  localparam logic [23:0] ClearBusyReset = 24'd2000;
  localparam logic [7:0]  SpaceChar      = 8'h20;

  localparam logic [CfgIndexW-1:0] CfgShortBusy = 1'b0;
  localparam logic [CfgIndexW-1:0] CfgClearBusy = 1'b1;

  localparam logic [7:0] InstrNop   = 8'h00;
  localparam logic [7:0] InstrClear = 8'h01;

  typedef enum logic {
    StIdle,
    StExec
  } state_e;

  typedef struct packed {
    logic       enable;
    logic       register_select;
    logic       read_not_write;
    logic [7:0] write_data;
  } in_word_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       busy_flag;
    logic [6:0] display_offset;
    logic [2:0] display_control;
    logic       four_bit_mode;
  } out_word_t;

endpackage

/* rtl/core/clcd_ram.sv */
// Generic single-port synchronous RAM with a registered read.
module clcd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/character_lcd_controller.sv */
// Top level of the character LCD controller: bus tick sequencer, state and RAMs.
//
//   Channel   Handshake          Payload
//   input     start, busy        in_word_i  (clcd_pkg::in_word_t)
//   result    done_o             out_word_o (clcd_pkg::out_word_t)
//   config    cfg_we_i           cfg_index_i, cfg_data_i
//
// For each bus tick word the RAMs are read at the accepting edge, and the execute state
// that follows modifies the state and writes the RAM back.
// The result word is shown on out_word_o with done_o high for one cycle, registered from
// the execute state; a new word may be accepted in that same cycle.
// After reset the RAMs read as zero at once through per-entry valid bits, so no
// clearing pass is needed; clear display drops the DDRAM valid bits likewise.
// The receiver cannot stall, so the result register never waits.
module character_lcd_controller (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  clcd_pkg::in_word_t                  in_word_i,
  output logic                                done_o,
  output clcd_pkg::out_word_t                 out_word_o,
  input  logic                                cfg_we_i,
  input  logic [clcd_pkg::CfgIndexW-1:0]      cfg_index_i,
  input  logic [clcd_pkg::CfgDataW-1:0]       cfg_data_i
);

  import clcd_pkg::*;

  function automatic logic [6:0] step7(input logic [6:0] v, input logic up);
    step7 = up ? v + 7'd1 : v - 7'd1;
  endfunction

  state_e state_q, state_d;

  in_word_t  item_q;
  out_word_t out_q, out_d;
  logic      done_q, done_d;

  logic [15:0] short_q;
  logic [23:0] clear_q;

  logic [6:0]  ac_q, ac_d;
  logic [6:0]  off_q, off_d;
  logic        dir_q, dir_d;
  logic        shift_q, shift_d;
  logic [2:0]  ocb_q, ocb_d;
  logic        nib_q, nib_d;
  logic        phase_q, phase_d;
  logic        cgsel_q, cgsel_d;
  logic [23:0] busy_cnt_q, busy_cnt_d;
  logic [7:0]  latch_q, latch_d;
  logic        prev_en_q, prev_en_d;
  logic        fill_space_q, fill_space_d;
  logic [DdramDepth-1:0] dd_valid_q, dd_valid_d;
  logic [CgramDepth-1:0] cg_valid_q, cg_valid_d;

  logic [23:0] busy_dec;
  logic        still_busy;
  logic        rd_edge;
  logic        wr_edge;
  logic        execute;
  logic        do_finish;
  logic [7:0]  dd_rdata;
  logic [7:0]  cg_rdata;
  logic [7:0]  ram_value;
  logic [7:0]  drive;
  logic [7:0]  instr;
  logic        dd_we;
  logic        cg_we;

  clcd_ram #(
    .Width (8),
    .Depth (DdramDepth)
  ) u_ddram (
    .clk_i   (clk_i),
    .we_i    (dd_we),
    .addr_i  (ac_q),
    .wdata_i (latch_d),
    .rdata_o (dd_rdata)
  );

  clcd_ram #(
    .Width (8),
    .Depth (CgramDepth)
  ) u_cgram (
    .clk_i   (clk_i),
    .we_i    (cg_we),
    .addr_i  (ac_q[CgAddrW-1:0]),
    .wdata_i (latch_d),
    .rdata_o (cg_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_q <= ShortBusyReset;
      clear_q <= ClearBusyReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgShortBusy: short_q <= cfg_data_i[15:0];
        CfgClearBusy: clear_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    busy    = 1'b0;
    case (state_q)
      StIdle: begin
        if (start) begin
          state_d = StExec;
        end
      end
      StExec: begin
        busy    = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      item_q <= in_word_i;
    end
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q       <= 1'b0;
      ac_q         <= '0;
      off_q        <= '0;
      dir_q        <= 1'b1;
      shift_q      <= 1'b0;
      ocb_q        <= 3'd7;
      nib_q        <= 1'b0;
      phase_q      <= 1'b0;
      cgsel_q      <= 1'b0;
      busy_cnt_q   <= '0;
      latch_q      <= '0;
      prev_en_q    <= 1'b0;
      fill_space_q <= 1'b0;
      dd_valid_q   <= '0;
      cg_valid_q   <= '0;
    end else begin
      done_q       <= done_d;
      ac_q         <= ac_d;
      off_q        <= off_d;
      dir_q        <= dir_d;
      shift_q      <= shift_d;
      ocb_q        <= ocb_d;
      nib_q        <= nib_d;
      phase_q      <= phase_d;
      cgsel_q      <= cgsel_d;
      busy_cnt_q   <= busy_cnt_d;
      latch_q      <= latch_d;
      prev_en_q    <= prev_en_d;
      fill_space_q <= fill_space_d;
      dd_valid_q   <= dd_valid_d;
      cg_valid_q   <= cg_valid_d;
    end
  end

  assign busy_dec   = (busy_cnt_q != '0) ? busy_cnt_q - 24'd1 : '0;
  assign still_busy = (busy_dec != '0);
  assign rd_edge    = item_q.read_not_write && !prev_en_q && item_q.enable;
  assign wr_edge    = !item_q.read_not_write && prev_en_q && !item_q.enable;
  assign ram_value  = cgsel_q ? (cg_valid_q[ac_q[CgAddrW-1:0]] ? cg_rdata : 8'h00)
                              : (dd_valid_q[ac_q] ? dd_rdata
                                                  : (fill_space_q ? SpaceChar : 8'h00));

  always_comb begin
    ac_d         = ac_q;
    off_d        = off_q;
    dir_d        = dir_q;
    shift_d      = shift_q;
    ocb_d        = ocb_q;
    nib_d        = nib_q;
    phase_d      = phase_q;
    cgsel_d      = cgsel_q;
    busy_cnt_d   = busy_cnt_q;
    latch_d      = latch_q;
    prev_en_d    = prev_en_q;
    fill_space_d = fill_space_q;
    dd_valid_d   = dd_valid_q;
    cg_valid_d   = cg_valid_q;
    drive        = '0;
    execute      = 1'b0;
    do_finish    = 1'b0;
    dd_we        = 1'b0;
    cg_we        = 1'b0;
    instr        = latch_q;
    done_d       = 1'b0;

    if (state_q == StExec) begin
      done_d     = 1'b1;
      busy_cnt_d = busy_dec;
      prev_en_d  = item_q.enable;

      if (rd_edge) begin
        if (item_q.register_select) begin
          if (!still_busy) begin
            latch_d   = ram_value;
            do_finish = !nib_q || phase_q;
          end
        end else begin
          latch_d = {still_busy, ac_q};
        end
        if (!nib_q) begin
          drive = latch_d;
        end else begin
          drive   = phase_q ? {latch_d[3:0], 4'h0} : {latch_d[7:4], 4'h0};
          phase_d = !phase_q;
        end
      end

      if (wr_edge) begin
        if (!nib_q) begin
          latch_d = item_q.write_data;
          execute = 1'b1;
        end else begin
          latch_d = phase_q ? {latch_q[7:4], item_q.write_data[7:4]}
                            : {item_q.write_data[7:4], latch_q[3:0]};
          phase_d = !phase_q;
          execute = phase_q;
        end
        instr = latch_d;
        if (execute && !still_busy) begin
          if (item_q.register_select) begin
            if (cgsel_q) begin
              cg_we                         = 1'b1;
              cg_valid_d[ac_q[CgAddrW-1:0]] = 1'b1;
            end else begin
              dd_we            = 1'b1;
              dd_valid_d[ac_q] = 1'b1;
            end
            do_finish = 1'b1;
          end else if (instr == InstrNop) begin
          end else if (instr == InstrClear) begin
            dd_valid_d   = '0;
            fill_space_d = 1'b1;
            ac_d         = '0;
            off_d        = '0;
            dir_d        = 1'b1;
            busy_cnt_d   = clear_q;
          end else begin
            if (instr[7:1] == 7'b0000001) begin
              ac_d  = '0;
              off_d = '0;
            end else if (instr[7:2] == 6'b000001) begin
              shift_d = instr[0];
              dir_d   = instr[1];
            end else if (instr[7:3] == 5'b00001) begin
              ocb_d = instr[2:0];
            end else if (instr[7:4] == 4'b0001) begin
              if (instr[3]) begin
                ac_d = step7(ac_q, instr[2]);
              end else begin
                off_d = step7(off_q, instr[2]);
              end
            end else if (instr[7:5] == 3'b001) begin
              nib_d   = !instr[4];
              phase_d = 1'b0;
            end else if (instr[7:6] == 2'b01) begin
              ac_d    = {1'b0, instr[5:0]};
              cgsel_d = 1'b1;
            end else begin
              ac_d    = instr[6:0];
              cgsel_d = 1'b0;
            end
            busy_cnt_d = {8'h00, short_q};
          end
        end
      end

      if (do_finish) begin
        if (cgsel_q) begin
          ac_d = step7(ac_q, 1'b1);
        end else begin
          ac_d = step7(ac_q, dir_q);
          if (shift_q) begin
            off_d = step7(off_q, dir_q);
          end
        end
        busy_cnt_d = {8'h00, short_q};
      end
    end

    out_d.read_data       = drive;
    out_d.busy_flag       = (busy_cnt_d != '0);
    out_d.display_offset  = off_d;
    out_d.display_control = ocb_d;
    out_d.four_bit_mode   = nib_d;
  end

  assign done_o     = done_q;
  assign out_word_o = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##2 done_o)
    else $error("Result word did not follow an accepted bus tick.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("Result strobe held for more than one cycle.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (out_word_o.busy_flag == (busy_cnt_q != '0)))
    else $error("Busy flag disagrees with the busy countdown.");

endmodule

/* verif/character_lcd_controller_tb.sv */
// Testbench for the character LCD controller: bus cycles checked against a predictor.
`timescale 1ns / 100ps

module character_lcd_controller_tb;
  import clcd_pkg::*;

  localparam logic [7:0] InstrHome     = 8'h02;
  localparam logic [7:0] InstrEntry    = 8'h04;
  localparam logic [7:0] InstrDisplay  = 8'h08;
  localparam logic [7:0] InstrShift    = 8'h10;
  localparam logic [7:0] InstrFunction = 8'h20;
  localparam logic [7:0] InstrCgAddr   = 8'h40;
  localparam logic [7:0] InstrDdAddr   = 8'h80;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  in_word_t             in_word_i;
  logic                 done_o;
  out_word_t            out_word_o;
  logic                 cfg_we_i;
  logic [CfgIndexW-1:0] cfg_index_i;
  logic [CfgDataW-1:0]  cfg_data_i;

  character_lcd_controller u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .in_word_i   (in_word_i),
    .done_o      (done_o),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  logic [7:0]  lcd_ddram [DdramDepth];
  logic [7:0]  lcd_cgram [CgramDepth];
  logic [6:0]  lcd_addr;
  logic [6:0]  lcd_shift;
  logic        lcd_inc;
  logic        lcd_entry_shift;
  logic [2:0]  lcd_ctrl;
  logic        lcd_nibble;
  logic        lcd_phase;
  logic        lcd_cg_sel;
  logic [23:0] lcd_busy_cnt;
  logic [7:0]  lcd_latch;
  logic        lcd_prev_en;
  logic [15:0] cfg_short_ticks;
  logic [23:0] cfg_clear_ticks;

  out_word_t expected_words[$];
  int        errors;
  int        idle_pct;
  int        tick_count;

  function automatic logic [6:0] step_addr(input logic [6:0] v, input logic up);
    return up ? v + 7'd1 : v - 7'd1;
  endfunction

  function automatic void finish_access();
    if (lcd_cg_sel) begin
      lcd_addr = step_addr(lcd_addr, 1'b1);
    end else begin
      lcd_addr = step_addr(lcd_addr, lcd_inc);
      if (lcd_entry_shift) lcd_shift = step_addr(lcd_shift, lcd_inc);
    end
    lcd_busy_cnt = {8'h00, cfg_short_ticks};
  endfunction

  function automatic void run_instruction(input logic [7:0] d);
    if (d == InstrNop) return;
    if (d == InstrClear) begin
      foreach (lcd_ddram[i]) lcd_ddram[i] = SpaceChar;
      lcd_addr = '0;
      lcd_shift = '0;
      lcd_inc = 1'b1;
      lcd_busy_cnt = cfg_clear_ticks;
      return;
    end
    if ((d & 8'hfe) == InstrHome) begin
      lcd_addr = '0;
      lcd_shift = '0;
    end else if ((d & 8'hfc) == InstrEntry) begin
      lcd_entry_shift = d[0];
      lcd_inc = d[1];
    end else if ((d & 8'hf8) == InstrDisplay) begin
      lcd_ctrl = d[2:0];
    end else if ((d & 8'hf0) == InstrShift) begin
      if (d[3]) lcd_addr = step_addr(lcd_addr, d[2]);
      else lcd_shift = step_addr(lcd_shift, d[2]);
    end else if ((d & 8'he0) == InstrFunction) begin
      lcd_nibble = ~d[4];
      lcd_phase = 1'b0;
    end else if ((d & 8'hc0) == InstrCgAddr) begin
      lcd_addr = {1'b0, d[5:0]};
      lcd_cg_sel = 1'b1;
    end else begin
      lcd_addr = d[6:0];
      lcd_cg_sel = 1'b0;
    end
    lcd_busy_cnt = {8'h00, cfg_short_ticks};
  endfunction

  function automatic out_word_t lcd_tick(input in_word_t w);
    out_word_t  r;
    logic [7:0] drive;
    logic       execute;
    drive = '0;
    execute = 1'b0;
    if (lcd_busy_cnt != 0) lcd_busy_cnt = lcd_busy_cnt - 24'd1;
    if (w.read_not_write && !lcd_prev_en && w.enable) begin
      if (w.register_select) begin
        if (lcd_busy_cnt == 0) begin
          lcd_latch = lcd_cg_sel ? lcd_cgram[lcd_addr[5:0]] : lcd_ddram[lcd_addr];
          if (!lcd_nibble || lcd_phase) finish_access();
        end
      end else begin
        lcd_latch = {lcd_busy_cnt != 0, lcd_addr};
      end
      if (!lcd_nibble) begin
        drive = lcd_latch;
      end else begin
        drive = lcd_phase ? {lcd_latch[3:0], 4'h0} : {lcd_latch[7:4], 4'h0};
        lcd_phase = ~lcd_phase;
      end
    end
    if (!w.read_not_write && lcd_prev_en && !w.enable) begin
      if (!lcd_nibble) begin
        lcd_latch = w.write_data;
        execute = 1'b1;
      end else begin
        if (!lcd_phase) lcd_latch[7:4] = w.write_data[7:4];
        else lcd_latch[3:0] = w.write_data[7:4];
        lcd_phase = ~lcd_phase;
        execute = ~lcd_phase;
      end
      if (execute && lcd_busy_cnt == 0) begin
        if (w.register_select) begin
          if (lcd_cg_sel) lcd_cgram[lcd_addr[5:0]] = lcd_latch;
          else lcd_ddram[lcd_addr] = lcd_latch;
          finish_access();
        end else begin
          run_instruction(lcd_latch);
        end
      end
    end
    lcd_prev_en = w.enable;
    r.read_data = drive;
    r.busy_flag = lcd_busy_cnt != 0;
    r.display_offset = lcd_shift;
    r.display_control = lcd_ctrl;
    r.four_bit_mode = lcd_nibble;
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned want, got);
    if (want != got) begin
      if (errors < 100)
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin : check_results
    out_word_t want;
    if (rst_ni && done_o) begin
      if (expected_words.size() == 0) begin
        if (errors < 100)
          $display("%0t: unexpected word, expected none, actual %p", $time, out_word_o);
        errors++;
      end else begin
        want = expected_words.pop_front();
        check_field("read_data", 32'(want.read_data), 32'(out_word_o.read_data));
        check_field("busy_flag", 32'(want.busy_flag), 32'(out_word_o.busy_flag));
        check_field("display_offset", 32'(want.display_offset),
                    32'(out_word_o.display_offset));
        check_field("display_control", 32'(want.display_control),
                    32'(out_word_o.display_control));
        check_field("four_bit_mode", 32'(want.four_bit_mode),
                    32'(out_word_o.four_bit_mode));
      end
    end
  end

  task automatic drive_tick(input logic en, input logic rs, input logic rw,
                            input logic [7:0] data);
    in_word_t w;
    w.enable = en;
    w.register_select = rs;
    w.read_not_write = rw;
    w.write_data = data;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (busy);
    expected_words.push_back(lcd_tick(w));
    tick_count++;
  endtask

  task automatic write_byte(input logic rs, input logic [7:0] b);
    logic [7:0] r;
    r = 8'($urandom);
    if (!lcd_nibble) begin
      drive_tick(1'b1, rs, 1'b0, b);
      drive_tick(1'b0, rs, 1'b0, b);
    end else begin
      drive_tick(1'b1, rs, 1'b0, {b[7:4], r[3:0]});
      drive_tick(1'b0, rs, 1'b0, {b[7:4], r[7:4]});
      r = 8'($urandom);
      drive_tick(1'b1, rs, 1'b0, {b[3:0], r[3:0]});
      drive_tick(1'b0, rs, 1'b0, {b[3:0], r[7:4]});
    end
  endtask

  task automatic read_nibble(input logic rs);
    drive_tick(1'b0, rs, 1'b1, 8'($urandom));
    drive_tick(1'b1, rs, 1'b1, 8'($urandom));
  endtask

  task automatic read_word(input logic rs);
    read_nibble(rs);
    if (lcd_nibble && lcd_phase) read_nibble(rs);
  endtask

  task automatic sync_phase();
    if (lcd_nibble && lcd_phase) read_nibble(1'b0);
  endtask

  task automatic wait_ready();
    while (lcd_busy_cnt != 0) begin
      if ($urandom_range(3) == 0) read_word(1'b0);
      else drive_tick(1'b0, 1'($urandom), 1'b1, 8'($urandom));
    end
  endtask

  task automatic set_config(input logic [15:0] short_ticks, input logic [23:0] clear_ticks);
    start <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= CfgShortBusy;
    cfg_data_i <= {8'h00, short_ticks};
    @(posedge clk_i);
    cfg_short_ticks = short_ticks;
    cfg_index_i <= CfgClearBusy;
    cfg_data_i <= clear_ticks;
    @(posedge clk_i);
    cfg_clear_ticks = clear_ticks;
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [7:0] random_instruction();
    logic [7:0] r;
    r = 8'($urandom);
    case ($urandom_range(9))
      0: return InstrNop;
      1: return InstrClear;
      2: return InstrHome | (r & 8'h01);
      3: return InstrEntry | (r & 8'h03);
      4: return InstrDisplay | (r & 8'h07);
      5: return InstrShift | (r & 8'h0f);
      6: return InstrFunction | (r & 8'h1f);
      7: return InstrCgAddr | (r & 8'h3f);
      default: return InstrDdAddr | (r & 8'h7f);
    endcase
  endfunction

  task automatic test_reset_defaults();
    read_word(1'b0);
    read_word(1'b1);
    read_word(1'b0);
    write_byte(1'b0, InstrDisplay | 8'h07);
    write_byte(1'b1, 8'hff);
    read_word(1'b1);
    wait_ready();
    write_byte(1'b0, InstrNop);
    read_word(1'b0);
  endtask

  task automatic test_instructions();
    write_byte(1'b0, InstrClear);
    read_word(1'b1);
    write_byte(1'b0, InstrDdAddr | 8'h7f);
    write_byte(1'b1, 8'hff);
    read_word(1'b0);
    for (int k = 0; k < 4; k++) begin
      write_byte(1'b0, InstrEntry | 8'(k));
      write_byte(1'b1, 8'($urandom));
    end
    write_byte(1'b0, InstrDisplay);
    write_byte(1'b0, InstrDisplay | 8'h07);
    for (int k = 0; k < 4; k++) write_byte(1'b0, InstrShift | 8'(k << 2));
    write_byte(1'b0, InstrHome | 8'h01);
    write_byte(1'b0, InstrCgAddr | 8'h3f);
    write_byte(1'b1, 8'h00);
    write_byte(1'b1, 8'hff);
    write_byte(1'b0, InstrCgAddr | 8'h3f);
    read_word(1'b1);
    read_word(1'b1);
    write_byte(1'b0, InstrDdAddr);
    read_word(1'b1);
  endtask

  task automatic test_nibble_mode();
    write_byte(1'b0, InstrFunction);
    wait_ready();
    read_word(1'b0);
    write_byte(1'b1, 8'h5a);
    wait_ready();
    write_byte(1'b0, InstrDdAddr | 8'h7f);
    wait_ready();
    read_word(1'b1);
    write_byte(1'b0, InstrClear);
    read_word(1'b0);
    read_word(1'b1);
    wait_ready();
    read_word(1'b1);
    drive_tick(1'b1, 1'b0, 1'b0, 8'hf0);
    drive_tick(1'b0, 1'b0, 1'b0, 8'h30);
    sync_phase();
    wait_ready();
    write_byte(1'b0, InstrFunction | 8'h10);
    wait_ready();
  endtask

  task automatic test_random(input int pct, input int n);
    int first;
    int pick;
    idle_pct = pct;
    first = tick_count;
    while (tick_count - first < n) begin
      sync_phase();
      if ($urandom_range(9) < 8) wait_ready();
      pick = $urandom_range(19);
      if (pick < 6) begin
        write_byte(1'b1, 8'($urandom));
      end else if (pick < 9) begin
        read_word(1'b1);
      end else if (pick < 11) begin
        read_word(1'b0);
      end else if (pick < 17) begin
        write_byte(1'b0, random_instruction());
      end else if (pick < 19) begin
        repeat ($urandom_range(1, 4))
          drive_tick(1'($urandom), 1'($urandom), 1'($urandom), 8'($urandom));
      end else begin
        drive_tick(1'b1, 1'($urandom), 1'b0, 8'($urandom));
        read_nibble(1'($urandom));
      end
    end
  endtask

  task automatic test_long_busy();
    idle_pct = 0;
    set_config(16'hffff, 24'hffffff);
    sync_phase();
    wait_ready();
    write_byte(1'b0, InstrDisplay | 8'h04);
    read_word(1'b0);
    write_byte(1'b1, 8'h33);
    write_byte(1'b0, InstrClear);
    read_word(1'b0);
    read_word(1'b1);
    write_byte(1'b1, 8'hcc);
    read_word(1'b0);
  endtask

  initial begin
    foreach (lcd_ddram[i]) lcd_ddram[i] = '0;
    foreach (lcd_cgram[i]) lcd_cgram[i] = '0;
    lcd_addr = '0;
    lcd_shift = '0;
    lcd_inc = 1'b1;
    lcd_entry_shift = 1'b0;
    lcd_ctrl = 3'd7;
    lcd_nibble = 1'b0;
    lcd_phase = 1'b0;
    lcd_cg_sel = 1'b0;
    lcd_busy_cnt = '0;
    lcd_latch = '0;
    lcd_prev_en = 1'b0;
    cfg_short_ticks = ShortBusyReset;
    cfg_clear_ticks = ClearBusyReset;
    errors = 0;
    idle_pct = 0;
    tick_count = 0;
    rst_ni = 1'b0;
    start <= 1'b0;
    in_word_i <= '0;
    cfg_we_i <= 1'b0;
    cfg_index_i <= CfgShortBusy;
    cfg_data_i <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    set_config(16'd0, 24'd0);
    test_instructions();
    set_config(16'd3, 24'd12);
    test_nibble_mode();
    set_config(16'd0, 24'd0);
    test_random(0, 180);
    set_config(16'($urandom_range(1, 6)), 24'($urandom_range(0, 30)));
    test_random(64, 180);
    set_config(16'($urandom_range(0, 6)), 24'($urandom_range(0, 30)));
    test_random(0, 180);
    set_config(16'($urandom_range(1, 10)), 24'($urandom_range(10, 60)));
    test_random(18, 180);
    test_long_busy();
    start <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
